FILE: rtl/core/magic_record_stream_walker_core_defines.svh
// Assertion macros shared by the record stream walker modules.
`ifndef MAGIC_RECORD_STREAM_WALKER_CORE_DEFINES_SVH
`define MAGIC_RECORD_STREAM_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define MRSW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define MRSW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mrsw_pkg.sv
// Shared types and constants for the record stream walker.
package mrsw_pkg;

  localparam int unsigned TAG_WINDOW_DEFAULT  = 80;
  localparam int unsigned OFFSET_BITS_DEFAULT = 32;
  localparam int unsigned IN_QUEUE_DEPTH      = 2;
  localparam int unsigned OUT_QUEUE_DEPTH     = 2;

  localparam logic [0:0]  REG_STREAM_LENGTH = 1'b0;
  localparam logic [0:0]  REG_SCAN_LIMIT    = 1'b1;
  localparam logic [31:0] SCAN_LIMIT_RESET  = 32'd4096;

  localparam logic [31:0] MAGIC_WORD = 32'h99C0FFEE;
  localparam logic [7:0]  DOT        = 8'h2E;
  localparam logic [7:0]  UNDERSCORE = 8'h5F;

  // Per-byte classification passed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        is_letter;
    logic        is_word;
    logic        is_dot;
    logic        magic_lo;   // magic in the last four bytes
    logic        magic_hi;   // magic in the four bytes before those
    logic        pos_ok;     // position at least 7
    logic [31:0] word_lo;    // little-endian word of the last four bytes
    logic [31:0] word_hi;    // little-endian word of the four bytes before
    logic [32:0] start_idx;  // magic start position, saturated
    logic [32:0] fit_end;    // end of a first record found here, saturated
    logic [31:0] first_off;  // size field offset of a first record found here
  } byte_info_t;

  typedef struct packed {
    logic [31:0] record_offset;
    logic [31:0] record_key;
    logic [31:0] record_size;
    logic [31:0] body_offset;
    logic [39:0] tag_text;
    logic [2:0]  tag_length;
  } record_t;

  // Configuration with the values derived at write time.
  typedef struct packed {
    logic [31:0] stream_length;
    logic [31:0] length_m8;   // stream_length - 8
    logic [32:0] scan_end;    // scan_limit + 4
    logic        length_ok;   // stream_length >= 12
  } cfg_t;

endpackage

FILE: rtl/core/magic_record_stream_walker_core.sv
// Record stream walker top level: configuration, front, queues and back end.
// Takes one byte per cycle while full is low. The byte that settles a tag is
// held in the input queue and its descriptor in the result queue; the back end
// stalls only while that queue is full. The two-entry input queue sets full.
// Reset (rst, synchronous): queues empty, parse back to searching,
// stream_length 0, scan_limit 4096.
module magic_record_stream_walker_core #(
  parameter int unsigned TAG_WINDOW  = mrsw_pkg::TAG_WINDOW_DEFAULT,
  parameter int unsigned OFFSET_BITS = mrsw_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        stream_start,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] record_offset,
  output logic [31:0] record_key,
  output logic [31:0] record_size,
  output logic [31:0] body_offset,
  output logic [39:0] tag_text,
  output logic [2:0]  tag_length
);
  import mrsw_pkg::*;

  localparam int unsigned INFO_W = $bits(byte_info_t);
  localparam int unsigned REC_W  = $bits(record_t);

  cfg_t               cfg;
  byte_info_t         front_info, back_info;
  record_t            back_rec, head_rec;
  logic [INFO_W-1:0]  in_rdata;
  logic [REC_W-1:0]   out_rdata;
  logic               accept, in_empty, in_pop;
  logic               out_full, out_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stream_length <= '0;
      cfg.length_m8     <= '0;
      cfg.scan_end      <= {1'b0, SCAN_LIMIT_RESET} + 33'd4;
      cfg.length_ok     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STREAM_LENGTH: begin
          cfg.stream_length <= cfg_data;
          cfg.length_m8     <= cfg_data - 32'd8;
          cfg.length_ok     <= (cfg_data >= 32'd12);
        end
        REG_SCAN_LIMIT: begin
          cfg.scan_end <= {1'b0, cfg_data} + 33'd4;
        end
        default: begin
          cfg.scan_end <= cfg.scan_end;
        end
      endcase
    end
  end

  assign accept = push && !full;

  mrsw_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .stream_start (stream_start),
    .info         (front_info)
  );

  mrsw_queue #(
    .WIDTH (INFO_W),
    .DEPTH (IN_QUEUE_DEPTH)
  ) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_info),
    .full  (full),
    .pop   (in_pop),
    .rdata (in_rdata),
    .empty (in_empty)
  );

  assign back_info = in_rdata;

  mrsw_back #(
    .TAG_WINDOW (TAG_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!in_empty),
    .info     (back_info),
    .in_pop   (in_pop),
    .cfg      (cfg),
    .out_full (out_full),
    .out_push (out_push),
    .out_rec  (back_rec)
  );

  mrsw_queue #(
    .WIDTH (REC_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (back_rec),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign head_rec      = out_rdata;
  assign record_offset = head_rec.record_offset;
  assign record_key    = head_rec.record_key;
  assign record_size   = head_rec.record_size;
  assign body_offset   = head_rec.body_offset;
  assign tag_text      = head_rec.tag_text;
  assign tag_length    = head_rec.tag_length;

endmodule

FILE: rtl/core/mrsw_queue.sv
// Small register queue with full and empty flags.
`include "magic_record_stream_walker_core_defines.svh"

module mrsw_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  `MRSW_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count past depth")
  `MRSW_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + CNT_W'(1), "queue count did not rise")
  `MRSW_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - CNT_W'(1), "queue count did not fall")

endmodule

FILE: rtl/core/mrsw_front.sv
// Front end: byte position, recent-byte window and per-byte classification.
module mrsw_front #(
  parameter int unsigned OFFSET_BITS = mrsw_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 stream_start,
  output mrsw_pkg::byte_info_t info
);
  import mrsw_pkg::*;

  localparam int unsigned SW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  logic [OFFSET_BITS-1:0] position, position_next;
  logic [63:0]            window, window_next;
  logic [SW-1:0]          pos_ext, size_ext, idx_full, end_full, off_full;
  logic [31:0]            word_hi;

  function automatic logic letter_f(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic word_f(input logic [7:0] c);
    return letter_f(c) || (c >= 8'h30 && c <= 8'h39) || (c == UNDERSCORE);
  endfunction

  // Position holds at its maximum instead of wrapping.
  assign position_next = stream_start ? '0 :
                         (position != '1) ? position + OFFSET_BITS'(1) : position;
  assign window_next   = stream_start ? {56'd0, data_byte} : {window[55:0], data_byte};

  assign word_hi  = {window_next[39:32], window_next[47:40],
                     window_next[55:48], window_next[63:56]};
  assign pos_ext  = SW'(position_next);
  assign size_ext = SW'(word_hi);
  assign idx_full = pos_ext - SW'(3);
  assign end_full = pos_ext + SW'(5) + size_ext;
  assign off_full = pos_ext - SW'(7);

  always_comb begin
    info.data      = data_byte;
    info.start     = stream_start;
    info.is_letter = letter_f(data_byte);
    info.is_word   = word_f(data_byte);
    info.is_dot    = (data_byte == DOT);
    info.magic_lo  = (window_next[31:0] == MAGIC_WORD);
    info.magic_hi  = (window_next[63:32] == MAGIC_WORD);
    info.pos_ok    = (pos_ext >= SW'(7));
    info.word_lo   = {window_next[7:0], window_next[15:8],
                      window_next[23:16], window_next[31:24]};
    info.word_hi   = word_hi;
    info.start_idx = (|idx_full[SW-1:33]) ? '1 : idx_full[32:0];
    info.fit_end   = (|end_full[SW-1:33]) ? '1 : end_full[32:0];
    info.first_off = off_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      window   <= '0;
    end else if (accept) begin
      position <= position_next;
      window   <= window_next;
    end
  end

endmodule

FILE: rtl/core/mrsw_back.sv
// Back end: record walk, header checks, tag search and descriptor output.
`include "magic_record_stream_walker_core_defines.svh"

module mrsw_back #(
  parameter int unsigned TAG_WINDOW = mrsw_pkg::TAG_WINDOW_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  mrsw_pkg::byte_info_t info,
  output logic                 in_pop,
  input  mrsw_pkg::cfg_t       cfg,
  input  logic                 out_full,
  output logic                 out_push,
  output mrsw_pkg::record_t    out_rec
);
  import mrsw_pkg::*;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam logic [3:0]  HDR_SIZE_DONE   = 4'd4;
  localparam logic [3:0]  HDR_FROM_SEARCH = 4'd8;
  localparam logic [3:0]  HDR_LAST        = 4'd12;
  localparam logic [31:0] WIN_MAX         = 32'(TAG_WINDOW);

  logic [1:0]  phase, phase_next;
  logic [31:0] cur_offset, offset_next;
  logic [31:0] cur_size, size_next;
  logic [31:0] cur_key, key_next;
  logic [3:0]  hdr_count, hdr_count_next, hdr_inc;
  logic [31:0] body_idx, body_idx_next, win;
  logic [39:0] tag_cand, tag_cand_next;
  logic [2:0]  letter_run, letter_run_next, run_inc;
  logic        cand_active, cand_active_next;
  logic        tag_settled, tag_settled_next;
  logic [33:0] rec_end;
  logic        step, emit, advance;

  assign step   = in_valid && !out_full;
  assign in_pop = step;
  assign hdr_inc = hdr_count + 4'd1;
  assign run_inc = letter_run + 3'd1;
  assign win     = (cur_size < WIN_MAX) ? cur_size : WIN_MAX;

  // End of the current record; offset and size settle well before use.
  always_ff @(posedge clk) begin
    rec_end <= {2'b00, cur_offset} + 34'd12 + {2'b00, cur_size};
  end

  always_comb begin
    phase_next       = phase;
    offset_next      = cur_offset;
    size_next        = cur_size;
    key_next         = cur_key;
    hdr_count_next   = hdr_count;
    body_idx_next    = body_idx;
    tag_cand_next    = tag_cand;
    letter_run_next  = letter_run;
    cand_active_next = cand_active;
    tag_settled_next = tag_settled;
    emit             = 1'b0;
    advance          = 1'b0;

    if (step) begin
      if (info.start) begin
        phase_next = PH_SEARCH;
      end else begin
        case (phase)
          PH_SEARCH: begin
            if (cfg.length_ok && info.pos_ok && info.magic_lo &&
                info.start_idx <= cfg.scan_end &&
                info.start_idx <= {1'b0, cfg.length_m8} &&
                info.fit_end <= {1'b0, cfg.stream_length}) begin
              offset_next    = info.first_off;
              size_next      = info.word_hi;
              hdr_count_next = HDR_FROM_SEARCH;
              phase_next     = PH_HEADER;
            end
          end
          PH_HEADER: begin
            hdr_count_next = hdr_inc;
            if (hdr_inc == HDR_SIZE_DONE) begin
              size_next = info.word_lo;
            end
            if (hdr_inc == HDR_LAST) begin
              if (!info.magic_hi || rec_end > {2'b00, cfg.stream_length}) begin
                phase_next = PH_STOP;
              end else begin
                key_next         = info.word_lo;
                tag_cand_next    = '0;
                letter_run_next  = '0;
                cand_active_next = 1'b0;
                tag_settled_next = 1'b0;
                if (cur_size == '0) begin
                  // empty body: no tag, report now
                  tag_settled_next = 1'b1;
                  emit             = 1'b1;
                  advance          = 1'b1;
                end else begin
                  body_idx_next = '0;
                  phase_next    = PH_BODY;
                end
              end
            end
          end
          PH_BODY: begin
            if (!tag_settled) begin
              if (body_idx < WIN_MAX) begin
                if (cand_active && info.is_letter) begin
                  if (letter_run < 3'd4) begin
                    letter_run_next = run_inc;
                    case (run_inc)
                      3'd1:    tag_cand_next[15:8]  = info.data;
                      3'd2:    tag_cand_next[23:16] = info.data;
                      3'd3:    tag_cand_next[31:24] = info.data;
                      3'd4:    tag_cand_next[39:32] = info.data;
                      default: tag_cand_next        = tag_cand;
                    endcase
                  end else begin
                    // too many letters: drop this dot
                    cand_active_next = 1'b0;
                  end
                end else if (cand_active && letter_run >= 3'd2 && !info.is_word) begin
                  tag_settled_next = 1'b1;
                end else begin
                  cand_active_next = info.is_dot;
                  if (info.is_dot) begin
                    letter_run_next = '0;
                    tag_cand_next   = {32'd0, DOT};
                  end
                end
              end
              if (tag_settled_next) begin
                emit = 1'b1;
              end else if (body_idx == win - 32'd1) begin
                // window end settles the tag
                if (!(cand_active_next && letter_run_next >= 3'd2)) begin
                  cand_active_next = 1'b0;
                  tag_cand_next    = '0;
                  letter_run_next  = '0;
                end
                tag_settled_next = 1'b1;
                emit             = 1'b1;
              end
            end
            body_idx_next = body_idx + 32'd1;
            if (body_idx == cur_size - 32'd1) begin
              advance = 1'b1;
            end
          end
          PH_STOP: begin
            phase_next = PH_STOP;
          end
          default: begin
            phase_next = PH_STOP;
          end
        endcase

        if (advance) begin
          if ({1'b0, rec_end} + 35'd12 > {3'b000, cfg.stream_length}) begin
            phase_next = PH_STOP;
          end else begin
            offset_next    = rec_end[31:0];
            hdr_count_next = '0;
            phase_next     = PH_HEADER;
          end
        end
      end
    end
  end

  always_comb begin
    out_push              = emit;
    out_rec.record_offset = cur_offset;
    out_rec.record_key    = key_next;
    out_rec.record_size   = cur_size;
    out_rec.body_offset   = cur_offset + 32'd12;
    out_rec.tag_text      = cand_active_next ? tag_cand_next : 40'd0;
    out_rec.tag_length    = cand_active_next ? letter_run_next + 3'd1 : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      hdr_count   <= '0;
      body_idx    <= '0;
      letter_run  <= '0;
      cand_active <= 1'b0;
      tag_settled <= 1'b0;
    end else begin
      phase       <= phase_next;
      hdr_count   <= hdr_count_next;
      body_idx    <= body_idx_next;
      letter_run  <= letter_run_next;
      cand_active <= cand_active_next;
      tag_settled <= tag_settled_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_offset <= offset_next;
    cur_size   <= size_next;
    cur_key    <= key_next;
    tag_cand   <= tag_cand_next;
  end

  `MRSW_ASSERT_IMP(a_tag_len, out_push, out_rec.tag_length == 3'd0 || out_rec.tag_length == 3'd3 || out_rec.tag_length == 3'd4 || out_rec.tag_length == 3'd5, "tag length out of range")
  `MRSW_ASSERT_IMP(a_tag_dot, out_push && out_rec.tag_length != 3'd0, out_rec.tag_text[7:0] == DOT, "tag does not open with a dot")
  `MRSW_ASSERT_IMP(a_push_room, out_push, !out_full, "descriptor pushed into full queue")
  `MRSW_ASSERT_NEXT(a_stop_holds, phase == PH_STOP && !(step && info.start), phase == PH_STOP, "left stop without a stream start")

endmodule

FILE: sim/walk_check_pkg.sv
// Scoreboard for the record stream walker: byte-level predictor and descriptor checker.
package walk_check_pkg;
  import mrsw_pkg::*;

  typedef enum bit [1:0] {HUNT, IN_HEADER, IN_BODY, HALTED} walk_phase_e;

  localparam int unsigned HEADER_LEN = 12;
  localparam int unsigned TAG_SPAN   = 80;

  class walk_scoreboard;
    bit [63:0]   length_cfg;
    bit [63:0]   limit_cfg;
    bit [31:0]   pos;
    walk_phase_e phase;
    bit [63:0]   window8;
    bit [63:0]   rec_off;
    bit [63:0]   rec_size;
    bit [63:0]   into_rec;
    bit [31:0]   rec_key;
    bit [39:0]   tag_buf;
    bit [2:0]    letters;
    bit          tag_open;
    bit          tag_done;
    record_t     pending[$];
    int          errors;
    int          checked;
    int          tag_hits;

    function new();
      length_cfg = 0;
      limit_cfg  = SCAN_LIMIT_RESET;
      restart();
    endfunction

    function void restart();
      pos      = 0;
      phase    = HUNT;
      window8  = 0;
      rec_off  = 0;
      rec_size = 0;
      rec_key  = 0;
      into_rec = 0;
      tag_buf  = 0;
      letters  = 0;
      tag_open = 1'b0;
      tag_done = 1'b0;
    endfunction

    function void set_reg(bit [0:0] idx, bit [31:0] value);
      if (idx == REG_STREAM_LENGTH) length_cfg = value;
      else limit_cfg = value;
    endfunction

    // little-endian word whose first byte arrived 'age' bytes ago
    function bit [31:0] word_at(int age);
      bit [31:0] w;
      for (int k = 0; k < 4; k++) w[8*k +: 8] = window8[8*((age - k) & 7) +: 8];
      return w;
    endfunction

    function bit is_letter(bit [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // window end: keep a candidate only if it already has two letters
    function void close_tag();
      if (!(tag_open && letters >= 2)) begin
        tag_open = 1'b0;
        tag_buf  = 0;
        letters  = 0;
      end
      tag_done = 1'b1;
    endfunction

    function void queue_record();
      record_t r;
      r.record_offset = rec_off[31:0];
      r.record_key    = rec_key;
      r.record_size   = rec_size[31:0];
      r.body_offset   = 32'(rec_off + HEADER_LEN);
      r.tag_text      = tag_open ? tag_buf : '0;
      r.tag_length    = tag_open ? letters + 3'd1 : 3'd0;
      pending = {pending, r};
    endfunction

    function void next_header();
      bit [63:0] nxt;
      nxt = rec_off + HEADER_LEN + rec_size;
      if (nxt + HEADER_LEN > length_cfg) begin
        phase = HALTED;
      end else begin
        rec_off  = nxt;
        into_rec = 0;
        phase    = IN_HEADER;
      end
    endfunction

    function void note_input(bit [7:0] c, bit first);
      bit [63:0] lim;
      bit [63:0] last_start;
      bit [63:0] start_at;
      bit [63:0] sz;
      bit [63:0] win;
      bit [63:0] idx;
      bit        taken;
      if (first) restart();
      else if (pos != '1) pos++;
      window8 = {window8[55:0], c};
      case (phase)
        HUNT: begin
          if (length_cfg >= HEADER_LEN && pos >= 7 && window8[31:0] == MAGIC_WORD) begin
            lim = (limit_cfg < length_cfg - HEADER_LEN) ? limit_cfg : length_cfg - HEADER_LEN;
            last_start = (lim + 4 < length_cfg - 4) ? lim + 4 : length_cfg - 4;
            start_at = pos - 3;
            sz = word_at(7);
            if (start_at <= last_start && (start_at - 4) + HEADER_LEN + sz <= length_cfg) begin
              rec_off  = start_at - 4;
              rec_size = sz;
              into_rec = 8;
              phase    = IN_HEADER;
            end
          end
        end
        IN_HEADER: begin
          into_rec++;
          if (into_rec == 4) rec_size = word_at(3);
          if (into_rec >= HEADER_LEN) begin
            if (window8[63:32] != MAGIC_WORD || rec_off + HEADER_LEN + rec_size > length_cfg) begin
              phase = HALTED;
            end else begin
              rec_key  = word_at(3);
              tag_buf  = 0;
              letters  = 0;
              tag_open = 1'b0;
              tag_done = 1'b0;
              if (rec_size == 0) begin
                close_tag();
                queue_record();
                next_header();
              end else begin
                phase = IN_BODY;
              end
            end
          end
        end
        IN_BODY: begin
          win = (rec_size < TAG_SPAN) ? rec_size : TAG_SPAN;
          idx = into_rec - HEADER_LEN;
          if (!tag_done) begin
            if (idx < win) begin
              taken = 1'b0;
              if (tag_open) begin
                if (is_letter(c)) begin
                  taken = 1'b1;
                  if (letters < 4) begin
                    letters++;
                    tag_buf[8*letters +: 8] = c;
                  end else begin
                    tag_open = 1'b0;
                  end
                end else if (letters >= 2 &&
                             !(is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == UNDERSCORE)) begin
                  taken = 1'b1;
                  tag_done = 1'b1;
                end else begin
                  tag_open = 1'b0;
                end
              end
              if (!taken && c == DOT) begin
                tag_open = 1'b1;
                letters  = 0;
                tag_buf  = 40'(DOT);
              end
            end
            if (tag_done) begin
              queue_record();
            end else if (idx + 1 == win) begin
              close_tag();
              queue_record();
            end
          end
          into_rec++;
          if (idx + 1 >= rec_size) next_header();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, bit [63:0] want, bit [63:0] got);
      if (want != got) begin
        $display("%0t: descriptor %0d %s expected 0x%0h, got 0x%0h",
                 $time, checked, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(record_t got);
      record_t want;
      if (pending.size() == 0) begin
        $display("%0t: descriptor at offset 0x%0h arrived with none expected, got key 0x%0h",
                 $time, got.record_offset, got.record_key);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("record_offset", want.record_offset, got.record_offset);
      compare_field("record_key", want.record_key, got.record_key);
      compare_field("record_size", want.record_size, got.record_size);
      compare_field("body_offset", want.body_offset, got.body_offset);
      compare_field("tag_text", want.tag_text, got.tag_text);
      compare_field("tag_length", want.tag_length, got.tag_length);
      checked++;
      if (want.tag_length != 0) tag_hits++;
    endfunction
  endclass

endpackage

FILE: sim/magic_record_stream_walker_core_test.sv
// Randomized stream test of the record stream walker with a byte-level scoreboard.
module magic_record_stream_walker_core_test;
  import mrsw_pkg::*;
  import walk_check_pkg::*;

  localparam int TX_ITEMS      = 1900;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_write    = 1'b0;
  logic [0:0]  cfg_index    = REG_STREAM_LENGTH;
  logic [31:0] cfg_data     = '0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  data_byte    = '0;
  logic        stream_start = 1'b0;
  logic        pop          = 1'b0;
  logic        empty;
  logic [31:0] record_offset;
  logic [31:0] record_key;
  logic [31:0] record_size;
  logic [31:0] body_offset;
  logic [39:0] tag_text;
  logic [2:0]  tag_length;

  walk_scoreboard sb = new();

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         hold_asks   = 0;
  int         hold_served = 0;
  int         hold_left   = 0;
  int         bytes_sent  = 0;
  int         streams_sent = 0;
  int         cycle_count = 0;
  bit [7:0]   stream_q[$];

  magic_record_stream_walker_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .data_byte(data_byte), .stream_start(stream_start),
    .pop(pop), .empty(empty),
    .record_offset(record_offset), .record_key(record_key), .record_size(record_size),
    .body_offset(body_offset), .tag_text(tag_text), .tag_length(tag_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d descriptors still expected",
             cycle_count, sb.pending.size());
    $display("Test completed with failures");
    $finish;
  end

  // check results before noting the request of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty)
        sb.check_result({record_offset, record_key, record_size, body_offset,
                         tag_text, tag_length});
      if (push && !full) sb.note_input(data_byte, stream_start);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (hold_left > 0) begin
      pop = 1'b0;
      hold_left--;
    end else if (hold_asks != hold_served) begin
      pop = 1'b0;
      hold_left = HOLD_CYCLES;
      hold_served++;
    end else begin
      pop = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance, push still high
  task automatic send_byte(input bit [7:0] b, input bit first);
    if ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    data_byte = b;
    stream_start = first;
    push = 1'b1;
    do @(posedge clk); while (full);
    bytes_sent++;
    @(negedge clk);
  endtask

  // drop push, wait for every expected descriptor, then let queued bytes drain
  task automatic wait_idle();
    push = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input bit [31:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_reg(idx, value);
  endtask

  function automatic void add_byte(bit [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic void put_word(bit [31:0] w);
    for (int k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
  endfunction

  // magic goes out high byte first
  function automatic void put_magic(bit [31:0] m);
    for (int k = 3; k >= 0; k--) add_byte(m[8*k +: 8]);
  endfunction

  function automatic bit [7:0] rand_letter();
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  // letters, dots, word and non-word neighbors of the letter ranges, raw bytes
  function automatic bit [7:0] body_filler();
    bit [7:0] punct[10] = '{8'h20, 8'h2D, 8'h2F, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2C,
                            8'h3A, 8'h00};
    int r = $urandom_range(99);
    if (r < 40) return rand_letter();
    if (r < 50) return DOT;
    if (r < 65) return punct[$urandom_range(9)];
    if (r < 73) return 8'h30 + 8'($urandom_range(9));
    if (r < 78) return UNDERSCORE;
    return 8'($urandom);
  endfunction

  function automatic void add_record(int unsigned size, bit bad_magic);
    bit [31:0]   magic = MAGIC_WORD;
    int unsigned n = 0;
    int          r = $urandom_range(9);
    if (bad_magic) magic[8*$urandom_range(3) +: 8] ^= 8'(1 << $urandom_range(7));
    put_word(size);
    put_magic(magic);
    put_word(r == 0 ? 32'h0 : r == 1 ? 32'hFFFF_FFFF : $urandom);
    while (n < size) begin
      if ($urandom_range(99) < 12) begin
        add_byte(DOT);
        n++;
        repeat ($urandom_range(1, 6)) begin
          if (n < size) begin
            add_byte(rand_letter());
            n++;
          end
        end
      end else begin
        add_byte(body_filler());
        n++;
      end
    end
  endfunction

  function automatic void build_stream();
    int unsigned recs = $urandom_range(1, 6);
    int          r = $urandom_range(99);
    stream_q.delete();
    // magic too early to count, or a decoy whose size cannot fit
    if (r < 10) put_magic(MAGIC_WORD);
    else if (r < 25) begin
      put_word(32'hFFFF_FF00 | 32'($urandom_range(255)));
      put_magic(MAGIC_WORD);
    end
    repeat ($urandom_range(0, 12)) add_byte(body_filler());
    repeat (recs) begin
      r = $urandom_range(99);
      add_record(r < 25 ? 0 : r < 75 ? $urandom_range(1, 20) :
                 r < 93 ? $urandom_range(21, 90) : $urandom_range(91, 200),
                 $urandom_range(99) < 5);
    end
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
  endfunction

  task automatic send_stream(input bit keep_cfg);
    int unsigned len;
    int unsigned split;
    int          r;
    len = stream_q.size();
    if (!keep_cfg) begin
      r = $urandom_range(99);
      wait_idle();
      write_reg(REG_STREAM_LENGTH,
                r < 65 ? len : r < 75 ? len - $urandom_range(1, len < 15 ? len : 15) :
                r < 85 ? len + $urandom_range(1, 20) : r < 90 ? $urandom_range(0, 11) :
                r < 95 ? $urandom_range(12, 40) : 32'hFFFF_FFFF);
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: write_reg(REG_SCAN_LIMIT, 32'h0);
          1: write_reg(REG_SCAN_LIMIT, $urandom_range(0, 24));
          2: write_reg(REG_SCAN_LIMIT, SCAN_LIMIT_RESET);
          3: write_reg(REG_SCAN_LIMIT, 32'hFFFF_FFFF);
          default: write_reg(REG_SCAN_LIMIT, $urandom);
        endcase
      end
    end
    split = ($urandom_range(9) == 0) ? $urandom_range(1, len - 1) : 0;
    for (int k = 0; k < len; k++) begin
      // hold the stream, let it settle, and change a register mid-stream
      if (split != 0 && k == split) begin
        wait_idle();
        if ($urandom_range(1)) write_reg(REG_STREAM_LENGTH, $urandom_range(0, len + 16));
        else write_reg(REG_SCAN_LIMIT, $urandom_range(0, 32));
      end
      send_byte(stream_q[k], k == 0);
    end
    streams_sent++;
  endtask

  initial begin
    int directed_bytes;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty body at offset 0 with the tightest scan limit and an all-ones key
    write_reg(REG_STREAM_LENGTH, 12);
    write_reg(REG_SCAN_LIMIT, 32'h0);
    stream_q.delete();
    put_word(0);
    put_magic(MAGIC_WORD);
    put_word(32'hFFFF_FFFF);
    send_stream(1'b1);

    // four-letter tag closed by the window end
    wait_idle();
    write_reg(REG_STREAM_LENGTH, 17);
    write_reg(REG_SCAN_LIMIT, 32'hFFFF_FFFF);
    stream_q.delete();
    put_word(5);
    put_magic(MAGIC_WORD);
    put_word(32'h0);
    add_byte(DOT);
    add_byte(8'h61);
    add_byte(8'h5A);
    add_byte(8'h7A);
    add_byte(8'h41);
    send_stream(1'b1);
    wait_idle();
    write_reg(REG_STREAM_LENGTH, 0);
    directed_bytes = bytes_sent;

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 55 : 0;
      rx_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 30 : 0;
      if (ph == 0) begin
        // first stream runs with a zero stream length
        build_stream();
        send_stream(1'b1);
        // back-to-back empty records against a stalled receiver
        stream_q.delete();
        repeat (20) begin
          put_word(0);
          put_magic(MAGIC_WORD);
          put_word($urandom);
        end
        wait_idle();
        write_reg(REG_STREAM_LENGTH, stream_q.size());
        hold_asks++;
        send_stream(1'b1);
        wait_idle();
      end
      while (bytes_sent < directed_bytes + (ph + 1) * TX_ITEMS / 3) begin
        build_stream();
        send_stream($urandom_range(3) == 0);
      end
    end

    wait_idle();
    $display("Streamed %0d bytes in %0d streams over %0d cycles", bytes_sent, streams_sent,
             cycle_count);
    $display("Checked %0d record descriptors, %0d of them carrying a tag", sb.checked,
             sb.tag_hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
